/* hdl/rlm_pkg.sv */
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared types and constants for the request latency monitor.
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam logic [63:0] MIN_LATENCY_RESET = 64'd500000;
  localparam logic        OP_ISSUE          = 1'b0;
  localparam logic        OP_COMPLETE       = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the incoming word
    logic scan_clear; // restart the table scan
    logic scan_step;  // compare the entry at the scan pointer
    logic write_hit;  // overwrite the timestamp of the matching entry
    logic write_new;  // claim the first free entry
    logic free_hit;   // release the matching entry
    logic emit;       // present a result if the latency qualifies
  } rlm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op;         // operation of the captured word
    logic scan_done;  // the scan has seen every entry
    logic hit;        // a valid entry matched the key
    logic have_free;  // a free entry was seen
  } rlm_stat_t;

endpackage

/* hdl/rlm_ram.sv */
// ----------------------------------------------------------------------------
// rlm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rlm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/rlm_datapath.sv */
// ----------------------------------------------------------------------------
// rlm_datapath
// Key table, sequential scan, latency subtract and result registers.
// ----------------------------------------------------------------------------
module rlm_datapath #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op,
  input  logic [31:0]       device,
  input  logic [63:0]       sector,
  input  logic [63:0]       now_ns,
  input  logic [63:0]       task_ident,
  input  logic              min_latency_we,
  input  logic [63:0]       min_latency_wdata,
  input  rlm_pkg::rlm_cmd_t cmd,
  output rlm_pkg::rlm_stat_t stat,
  output logic              result_strobe,
  output logic [31:0]       process_id,
  output logic [31:0]       thread_id,
  output logic [63:0]       completion_ns,
  output logic [63:0]       latency_ns
);
  import rlm_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES);

  logic              cur_op;
  logic [31:0]       cur_device;
  logic [63:0]       cur_sector;
  logic [63:0]       cur_now;
  logic [63:0]       cur_task;
  logic [63:0]       min_latency;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CW-1:0]     scan;
  logic              cmp_pending;
  logic [AW-1:0]     cmp_addr;
  logic              hit;
  logic [AW-1:0]     hit_addr;
  logic              have_free;
  logic [AW-1:0]     free_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [159:0]      ram_wdata;
  logic [159:0]      ram_rdata;
  logic [63:0]       latency;
  logic              key_match;

  // Registered read: the address is driven in the cycle before the compare.
  always_comb begin
    ram_we    = cmd.write_hit | cmd.write_new;
    ram_addr  = scan[AW-1:0];
    if (cmd.write_new) begin
      ram_addr = free_addr;
    end else if (cmd.write_hit || cmd.free_hit) begin
      ram_addr = hit_addr;
    end
    ram_wdata = {cur_device, cur_sector, cur_now};
  end

  rlm_ram #(.WIDTH(160), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign key_match = valid[cmp_addr] && (ram_rdata[159:128] == cur_device) &&
                     (ram_rdata[127:64] == cur_sector);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      min_latency <= MIN_LATENCY_RESET;
      cmp_pending <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (min_latency_we) begin
        min_latency <= min_latency_wdata;
      end
      cmp_pending <= cmd.scan_step && (scan != LAST);
      if (cmd.write_new) begin
        valid[free_addr] <= 1'b1;
      end
      if (cmd.free_hit) begin
        valid[hit_addr] <= 1'b0;
      end
      if (cmd.emit && latency >= min_latency) begin
        result_strobe <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_op     <= op;
      cur_device <= device;
      cur_sector <= sector;
      cur_now    <= now_ns;
      cur_task   <= task_ident;
    end
    if (cmd.scan_clear) begin
      scan      <= '0;
      hit       <= 1'b0;
      have_free <= 1'b0;
    end else begin
      if (cmd.scan_step && scan != LAST) begin
        scan     <= scan + 1'b1;
        cmp_addr <= scan[AW-1:0];
      end
      if (cmp_pending) begin
        if (!hit && key_match) begin
          hit      <= 1'b1;
          hit_addr <= cmp_addr;
          latency  <= cur_now - ram_rdata[63:0];
        end
        if (!have_free && !valid[cmp_addr]) begin
          have_free <= 1'b1;
          free_addr <= cmp_addr;
        end
      end
    end
    if (cmd.emit) begin
      process_id    <= cur_task[63:32];
      thread_id     <= cur_task[31:0];
      completion_ns <= cur_now;
      latency_ns    <= latency;
    end
  end

  assign stat.op        = cur_op;
  assign stat.scan_done = (scan == LAST) && !cmp_pending;
  assign stat.hit       = hit;
  assign stat.have_free = have_free;
endmodule

/* hdl/rlm_ctrl.sv */
// ----------------------------------------------------------------------------
// rlm_ctrl
// Sequencer for capture, table scan and the final update of one word.
// ----------------------------------------------------------------------------
module rlm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rlm_pkg::rlm_stat_t stat,
  output rlm_pkg::rlm_cmd_t  cmd
);
  import rlm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture    = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        if (stat.op == OP_ISSUE) begin
          cmd.write_hit = stat.hit;
          cmd.write_new = !stat.hit && stat.have_free;
        end else begin
          cmd.free_hit = stat.hit;
          cmd.emit     = stat.hit;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_act_once: assert property (@(posedge clk) disable iff (rst)
    state == S_ACT |=> state == S_IDLE) else $error("action state repeated");
  a_write_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write_new && cmd.write_hit)) else $error("two table writes");
  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !busy) else $error("capture while busy");
endmodule

/* hdl/request_latency_monitor_core.sv */
// ----------------------------------------------------------------------------
// request_latency_monitor_core
// Tracks in-flight requests by device and sector and reports long latencies.
// ----------------------------------------------------------------------------
// A word runs from start through the table scan, which reads one entry per
// cycle from the RAM, to the result strobe.
// A new word is not taken until the last is done; busy is high meanwhile.
// Reset clears all valid bits at once and loads the threshold with 500000.
// Results are shown for one cycle; the receiver cannot stall.
module request_latency_monitor_core #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] device,
  input  logic [63:0] sector,
  input  logic [63:0] now_ns,
  input  logic [63:0] task_ident,
  input  logic        min_latency_ns_we,
  input  logic [63:0] min_latency_ns,
  output logic        result_strobe,
  output logic [31:0] process_id,
  output logic [31:0] thread_id,
  output logic [63:0] completion_ns,
  output logic [63:0] latency_ns
);
  import rlm_pkg::*;

  // The controller and datapath talk only through these two structs.
  rlm_cmd_t  cmd;
  rlm_stat_t stat;

  rlm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  // The datapath scans the table, keeps the first hit and first free entry,
  // and in the final cycle writes, or frees and emits the result word.
  rlm_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .op(op), .device(device), .sector(sector),
    .now_ns(now_ns), .task_ident(task_ident),
    .min_latency_we(min_latency_ns_we), .min_latency_wdata(min_latency_ns),
    .cmd(cmd), .stat(stat), .result_strobe(result_strobe),
    .process_id(process_id), .thread_id(thread_id),
    .completion_ns(completion_ns), .latency_ns(latency_ns)
  );
endmodule

/* tb/request_latency_monitor_core_tb.sv */
// ----------------------------------------------------------------------------
// request_latency_monitor_core_tb
// Self-checking testbench for the request latency monitor. A directed table
// of words covers the extremes and special cases, a fill phase fills the table,
// then random issue and completion traffic over a small key pool exercises hits,
// misses and overwrites. Every result is checked against a behavioral tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module request_latency_monitor_core_tb;
  import rlm_pkg::*;

  localparam int DEPTH     = 64;
  localparam int LIMIT_CYC = 400000;
  // Worst-case cycles from start to result strobe, plus margin.
  localparam int WORD_CYC  = DEPTH + 8;

  typedef struct packed {
    logic        op;
    logic [31:0] device;
    logic [63:0] sector;
    logic [63:0] now_ns;
    logic [63:0] task_ident;
  } req_word_t;

  typedef struct packed {
    logic [31:0] process_id;
    logic [31:0] thread_id;
    logic [63:0] completion_ns;
    logic [63:0] latency_ns;
  } lat_report_t;

  // One row of the directed table: a word and, where obvious, its outcome.
  typedef struct {
    req_word_t   word;
    bit          known;     // the expected outcome is typed in below
    bit          reported;
    lat_report_t report;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        op = OP_ISSUE;
  logic [31:0] device = '0;
  logic [63:0] sector = '0;
  logic [63:0] now_ns = '0;
  logic [63:0] task_ident = '0;
  logic        min_latency_ns_we = 1'b0;
  logic [63:0] min_latency_ns = '0;
  logic        result_strobe;
  logic [31:0] process_id;
  logic [31:0] thread_id;
  logic [63:0] completion_ns;
  logic [63:0] latency_ns;

  request_latency_monitor_core #(.TABLE_ENTRIES(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .device(device), .sector(sector), .now_ns(now_ns),
    .task_ident(task_ident), .min_latency_ns_we(min_latency_ns_we),
    .min_latency_ns(min_latency_ns), .result_strobe(result_strobe),
    .process_id(process_id), .thread_id(thread_id),
    .completion_ns(completion_ns), .latency_ns(latency_ns)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker state: our own copy of the in-flight table and the threshold.
  bit          trk_valid [DEPTH];
  logic [31:0] trk_device[DEPTH];
  logic [63:0] trk_sector[DEPTH];
  logic [63:0] trk_start [DEPTH];
  logic [63:0] trk_threshold;

  lat_report_t pending_reports[$];
  int          error_count = 0;
  int          cycle_count = 0;

  // Applies one accepted word to the tracker. Returns 1 when the block must
  // report a latency, with the report filled in.
  function automatic bit track_word(input req_word_t w, output lat_report_t r);
    int          slot;
    logic [63:0] lat;
    slot = -1;
    r = '0;
    for (int i = 0; i < DEPTH; i++)
      if (slot < 0 && trk_valid[i] && trk_device[i] == w.device &&
          trk_sector[i] == w.sector)
        slot = i;
    if (w.op == OP_ISSUE) begin
      if (slot < 0) begin
        for (int i = 0; i < DEPTH; i++)
          if (slot < 0 && !trk_valid[i])
            slot = i;
        // A new key with a full table is simply dropped.
        if (slot < 0)
          return 1'b0;
        trk_valid[slot]  = 1'b1;
        trk_device[slot] = w.device;
        trk_sector[slot] = w.sector;
      end
      trk_start[slot] = w.now_ns;
      return 1'b0;
    end
    if (slot < 0)
      return 1'b0;
    // Latency wraps modulo 2^64 when the issue time is the later one.
    lat = w.now_ns - trk_start[slot];
    trk_valid[slot] = 1'b0;
    if (lat < trk_threshold)
      return 1'b0;
    r.process_id    = w.task_ident[63:32];
    r.thread_id     = w.task_ident[31:0];
    r.completion_ns = w.now_ns;
    r.latency_ns    = lat;
    return 1'b1;
  endfunction

  // Result monitor: every strobe is matched against the oldest expectation.
  always @(posedge clk) begin
    lat_report_t exp_r;
    if (!rst && result_strobe) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: latency_ns %0d", latency_ns);
        error_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (process_id !== exp_r.process_id) begin
          $error("process_id: expected %h, got %h", exp_r.process_id, process_id);
          error_count++;
        end
        if (thread_id !== exp_r.thread_id) begin
          $error("thread_id: expected %h, got %h", exp_r.thread_id, thread_id);
          error_count++;
        end
        if (completion_ns !== exp_r.completion_ns) begin
          $error("completion_ns: expected %h, got %h", exp_r.completion_ns,
                 completion_ns);
          error_count++;
        end
        if (latency_ns !== exp_r.latency_ns) begin
          $error("latency_ns: expected %h, got %h", exp_r.latency_ns, latency_ns);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the overall run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYC) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  bit idle_on = 1'b1;

  // Drives one word at the falling edge and holds it until the block takes
  // it. Random idle bursts come before the word while idling is enabled.
  task automatic send_word(input req_word_t w);
    lat_report_t r;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 10)) @(negedge clk);
    op         <= w.op;
    device     <= w.device;
    sector     <= w.sector;
    now_ns     <= w.now_ns;
    task_ident <= w.task_ident;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    if (track_word(w, r))
      pending_reports.push_back(r);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Waits for every expected report, then for the longest word time, since
  // a word that reports nothing can still be in flight.
  task automatic drain();
    while (pending_reports.size() != 0)
      @(negedge clk);
    repeat (WORD_CYC) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [63:0] value);
    @(negedge clk);
    min_latency_ns    <= value;
    min_latency_ns_we <= 1'b1;
    @(negedge clk);
    min_latency_ns_we <= 1'b0;
    trk_threshold = value;
  endtask

  function automatic req_word_t mk_word(input logic o, input logic [31:0] d,
                                        input logic [63:0] s, input logic [63:0] t,
                                        input logic [63:0] k);
    req_word_t w;
    w.op = o; w.device = d; w.sector = s; w.now_ns = t; w.task_ident = k;
    return w;
  endfunction

  function automatic dir_row_t row(input req_word_t w, input bit kn, input bit rep,
                                   input logic [63:0] lat);
    dir_row_t x;
    x.word = w;
    x.known = kn;
    x.reported = rep;
    x.report.process_id    = w.task_ident[63:32];
    x.report.thread_id     = w.task_ident[31:0];
    x.report.completion_ns = w.now_ns;
    x.report.latency_ns    = lat;
    return x;
  endfunction

  // Random word over a small key pool so that completions often hit.
  function automatic req_word_t rand_word(input int pool, input int issue_pct);
    req_word_t w;
    int        key;
    key = $urandom_range(0, pool - 1);
    w.op         = ($urandom_range(0, 99) < issue_pct) ? OP_ISSUE : OP_COMPLETE;
    w.device     = (key % 4 == 3) ? 32'hFFFF_FFFF : key % 4;
    w.sector     = (key / 4 == 7) ? 64'hFFFF_FFFF_FFFF_FFF0 : 64'(key / 4);
    w.now_ns     = {$urandom, $urandom};
    w.task_ident = {$urandom, $urandom};
    return w;
  endfunction

  dir_row_t    dir_table[$];
  lat_report_t chk_r;
  logic [63:0] base_t;

  initial begin
    for (int i = 0; i < DEPTH; i++)
      trk_valid[i] = 1'b0;
    trk_threshold = MIN_LATENCY_RESET;

    // Directed table. Latencies are typed in only where they are obvious.
    dir_table.push_back(row(mk_word(OP_COMPLETE, 32'd5, 64'd9, 64'd1000, 64'd1),
                            1, 0, 0)); // completion on an empty table
    dir_table.push_back(row(mk_word(OP_ISSUE, 32'd1, 64'd2, 64'd0, 64'd0), 1, 0, 0));
    dir_table.push_back(row(mk_word(OP_COMPLETE, 32'd1, 64'd2, 64'd500000,
                            64'hFFFF_FFFF_0000_0000), 1, 1, 64'd500000));
    dir_table.push_back(row(mk_word(OP_ISSUE, 32'd1, 64'd2, 64'd0, 64'd0), 1, 0, 0));
    dir_table.push_back(row(mk_word(OP_COMPLETE, 32'd1, 64'd2, 64'd499999,
                            64'd7), 1, 0, 0)); // just below threshold, entry freed
    dir_table.push_back(row(mk_word(OP_COMPLETE, 32'd1, 64'd2, 64'd900000,
                            64'd7), 1, 0, 0)); // now a miss
    // Repeated issue keeps only the latest timestamp.
    dir_table.push_back(row(mk_word(OP_ISSUE, 32'hFFFF_FFFF, '1, 64'd10, 64'd0),
                            1, 0, 0));
    dir_table.push_back(row(mk_word(OP_ISSUE, 32'hFFFF_FFFF, '1, 64'd100, 64'd0),
                            1, 0, 0));
    dir_table.push_back(row(mk_word(OP_COMPLETE, 32'hFFFF_FFFF, '1, 64'd1000100,
                            '1), 1, 1, 64'd1000000));
    // Issue later than completion: latency wraps.
    dir_table.push_back(row(mk_word(OP_ISSUE, 32'd0, 64'd0, '1, 64'd0), 1, 0, 0));
    dir_table.push_back(row(mk_word(OP_COMPLETE, 32'd0, 64'd0, 64'd999999,
                            64'h1234_5678_9ABC_DEF0), 1, 1, 64'd1000000));
    // Same sector, other device, must not alias.
    dir_table.push_back(row(mk_word(OP_ISSUE, 32'd3, 64'h8000_0000_0000_0000,
                            64'h5555_5555_5555_5555, 64'd0), 0, 0, 0));
    dir_table.push_back(row(mk_word(OP_COMPLETE, 32'd4, 64'h8000_0000_0000_0000,
                            '1, 64'd0), 0, 0, 0));
    dir_table.push_back(row(mk_word(OP_COMPLETE, 32'd3, 64'h8000_0000_0000_0000,
                            64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_5555_5555_AAAA),
                            0, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      send_word(dir_table[i].word);
      if (dir_table[i].known && dir_table[i].reported) begin
        if (pending_reports.size() == 0) begin
          $error("latency_ns: expected %h from table, got no report from tracker",
                 dir_table[i].report.latency_ns);
          error_count++;
        end else begin
          chk_r = pending_reports[$];
          if (chk_r !== dir_table[i].report) begin
            $error("latency_ns: expected %h from table, got %h from tracker",
                   dir_table[i].report.latency_ns, chk_r.latency_ns);
            error_count++;
          end
        end
      end
    end

    // Fill the table, then a new key is ignored and an old key still works.
    drain();
    write_threshold('0);
    for (int i = 0; i < DEPTH; i++)
      send_word(mk_word(OP_ISSUE, 32'h100, 64'(i), 64'(i), {$urandom, $urandom}));
    send_word(mk_word(OP_ISSUE, 32'h200, 64'd0, 64'd5, 64'd0));
    send_word(mk_word(OP_COMPLETE, 32'h200, 64'd0, 64'd50, 64'd0));
    for (int i = 0; i < DEPTH; i += 2)
      send_word(mk_word(OP_COMPLETE, 32'h100, 64'(i), 64'(i + 3),
                        {$urandom, $urandom}));
    send_word(mk_word(OP_ISSUE, 32'h200, 64'd0, 64'd5, 64'd0));
    send_word(mk_word(OP_COMPLETE, 32'h200, 64'd0, 64'd50, 64'd0));
    for (int i = 1; i < DEPTH; i += 2)
      send_word(mk_word(OP_COMPLETE, 32'h100, 64'(i), 64'(i + 3), 64'd0));

    // Random phases at several thresholds, including both extremes.
    for (int ph = 0; ph < 4; ph++) begin
      drain(); // sender holds off until every report is in
      case (ph)
        0: write_threshold('1);
        1: write_threshold(64'd1 << $urandom_range(0, 63));
        2: write_threshold({1'b0, $urandom_range(0, 1) ? 63'd0 : 63'h7FFF_FFFF});
        default: write_threshold('0);
      endcase
      if (ph == 3)
        idle_on = 1'b0;
      for (int n = 0; n < 36; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          // Well-formed pair: an issue and its completion a bit later.
          chk_r = '0;
          base_t = {$urandom, $urandom};
          send_word(mk_word(OP_ISSUE, $urandom, {32'd0, $urandom_range(0, 7)},
                            base_t, {$urandom, $urandom}));
          send_word(mk_word(OP_COMPLETE, device, sector,
                            ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                            : base_t + $urandom, {$urandom, $urandom}));
        end else begin
          send_word(rand_word(40, 55));
        end
      end
    end

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
